/* sv/sprite_affine_matrix_builder_top_macros.svh */
// assertion macros for the sprite affine matrix builder
// no dependencies; included by the top level
`ifndef SPRITE_AFFINE_MATRIX_BUILDER_TOP_MACROS_SVH
`define SPRITE_AFFINE_MATRIX_BUILDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SAMB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("samb assertion failed");
`define SAMB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("samb assertion failed");
`else
`define SAMB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SAMB_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/samb_pkg.sv */
// types, constants and helpers of the sprite affine matrix builder
// no dependencies
package samb_pkg;

  localparam int unsigned AtanEntries = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  typedef enum logic [0:0] {
    REG_PIVOT_X = 1'b0,
    REG_PIVOT_Y = 1'b1
  } reg_idx_e;

  // payload of the sine/cosine stages
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [33:0] c;
    logic signed [33:0] s;
    logic signed [33:0] ns;
  } trig_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [67:0] p00;
    logic signed [67:0] p01;
    logic signed [67:0] p10;
    logic signed [67:0] p11;
    logic signed [67:0] crx;
    logic signed [67:0] sry;
    logic signed [67:0] srx;
    logic signed [67:0] cry;
  } prod_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [33:0] atan_turns(input int unsigned idx);
    logic signed [33:0] r;
    case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004757;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      default: r = 34'sd81;
    endcase
    return r;
  endfunction

  // round a Q2.30 product back to Q16.16: floor((p + 2^29) / 2^30)
  function automatic logic signed [37:0] rnd_q30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd536870912) >>> 30;
    return t[37:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/sprite_affine_matrix_builder_top.sv */
// pipeline: entry stage, the cordic stages, then the trig, multiply and output registers
// throughput: one beat per cycle while m_axis_tready holds; one register stage per cordic iteration
// sets the depth, the multiply stage sets the clock (up to 34x34 bit products)
// each stage advances whenever the stage after it is empty or moving
// reset: async active low, clears all valid bits and sets both pivots to one half
// depends on samb_pkg and sprite_affine_matrix_builder_top_macros.svh
`include "sprite_affine_matrix_builder_top_macros.svh"

module sprite_affine_matrix_builder_top
  import samb_pkg::*;
#(
  parameter int unsigned SINCOS_ITERATIONS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i,
  // input beats
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x[31:0], pos_y[63:32], angle_turns[79:64], scale_x[111:80], scale_y[143:112]
  input  logic [143:0] s_axis_tdata,
  // result beats
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m00[31:0], m01[63:32], m10[95:64], m11[127:96], trans_x[159:128], trans_y[191:160]
  output logic [191:0] m_axis_tdata
);

  // iterations beyond the table act as the last entry count
  localparam int unsigned NumIter =
    (SINCOS_ITERATIONS > AtanEntries) ? AtanEntries : SINCOS_ITERATIONS;

  // pivot registers
  logic signed [15:0] pivot_x_q, pivot_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_x_q <= 16'sd8192;
      pivot_y_q <= 16'sd8192;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PIVOT_X: pivot_x_q <= cfg_data_i;
        REG_PIVOT_Y: pivot_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0 is the entry stage, stage k holds the result of iteration k-1
  cordic_t         stg_q [NumIter+1];
  logic [NumIter:0] vld_q;
  logic [NumIter:0] rdy;

  trig_t trig_q;
  logic  trig_vld_q, trig_rdy;
  prod_t prod_q;
  logic  prod_vld_q, prod_rdy;
  logic  out_vld_q, out_rdy;
  logic [191:0] out_q;

  // backpressure chain: a stage may load when it is empty or drains
  assign out_rdy  = !out_vld_q || m_axis_tready;
  assign prod_rdy = !prod_vld_q || out_rdy;
  assign trig_rdy = !trig_vld_q || prod_rdy;
  assign rdy[NumIter] = !vld_q[NumIter] || trig_rdy;
  for (genvar k = 0; k < NumIter; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign s_axis_tready = rdy[0];

  // entry stage: unpack, pivot offset, quarter turn and residual angle
  logic signed [31:0] in_px, in_py, in_sx, in_sy;
  logic [15:0]        in_ang, in_res;
  logic [1:0]         in_quad;
  logic signed [47:0] rxp, ryp, rxr, ryr;
  cordic_t            ent_d;

  assign in_px  = s_axis_tdata[31:0];
  assign in_py  = s_axis_tdata[63:32];
  assign in_ang = s_axis_tdata[79:64];
  assign in_sx  = s_axis_tdata[111:80];
  assign in_sy  = s_axis_tdata[143:112];

  always_comb begin
    logic [15:0] ang_rnd;
    ang_rnd = in_ang + 16'h2000;
    in_quad = ang_rnd[15:14];
    // residual in [-1/8, 1/8) turn
    in_res  = in_ang - {in_quad, 14'b0};
    rxp = pivot_x_q * in_sx;
    ryp = pivot_y_q * in_sy;
    rxr = (rxp + 48'sd8192) >>> 14;
    ryr = (ryp + 48'sd8192) >>> 14;
    ent_d.pos_x   = in_px;
    ent_d.pos_y   = in_py;
    ent_d.scale_x = in_sx;
    ent_d.scale_y = in_sy;
    ent_d.rx      = rxr[33:0];
    ent_d.ry      = ryr[33:0];
    ent_d.x       = CordicGain;
    ent_d.y       = '0;
    ent_d.z       = {{2{in_res[15]}}, in_res, 16'b0};
    ent_d.quad    = in_quad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      stg_q[0] <= ent_d;
    end
  end

  // one cordic micro-rotation per stage, floor shifts
  for (genvar k = 1; k <= NumIter; k++) begin : g_cordic
    cordic_t nxt;

    always_comb begin
      logic signed [33:0] dx, dy;
      nxt = stg_q[k-1];
      dx  = stg_q[k-1].y >>> (k-1);
      dy  = stg_q[k-1].x >>> (k-1);
      if (!stg_q[k-1].z[33]) begin
        nxt.x = stg_q[k-1].x - dx;
        nxt.y = stg_q[k-1].y + dy;
        nxt.z = stg_q[k-1].z - atan_turns(k-1);
      end else begin
        nxt.x = stg_q[k-1].x + dx;
        nxt.y = stg_q[k-1].y - dy;
        nxt.z = stg_q[k-1].z + atan_turns(k-1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        stg_q[k] <= nxt;
      end
    end
  end

  // quarter-turn fold: cos, sin and minus sin
  cordic_t last;
  trig_t   trig_d;

  assign last = stg_q[NumIter];

  always_comb begin
    trig_d.pos_x   = last.pos_x;
    trig_d.pos_y   = last.pos_y;
    trig_d.scale_x = last.scale_x;
    trig_d.scale_y = last.scale_y;
    trig_d.rx      = last.rx;
    trig_d.ry      = last.ry;
    case (last.quad)
      2'd1: begin
        trig_d.c = -last.y;
        trig_d.s = last.x;
      end
      2'd2: begin
        trig_d.c = -last.x;
        trig_d.s = -last.y;
      end
      2'd3: begin
        trig_d.c = last.y;
        trig_d.s = -last.x;
      end
      default: begin
        trig_d.c = last.x;
        trig_d.s = last.y;
      end
    endcase
    trig_d.ns = -trig_d.s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_vld_q <= 1'b0;
    end else if (trig_rdy) begin
      trig_vld_q <= vld_q[NumIter];
    end
  end

  always_ff @(posedge clk_i) begin
    if (trig_rdy) begin
      trig_q <= trig_d;
    end
  end

  // multiply stage: every product with cos or sin, registered raw
  prod_t prod_d;

  always_comb begin
    prod_d.pos_x = trig_q.pos_x;
    prod_d.pos_y = trig_q.pos_y;
    prod_d.rx    = trig_q.rx;
    prod_d.ry    = trig_q.ry;
    prod_d.p00   = trig_q.c * trig_q.scale_x;
    prod_d.p01   = trig_q.ns * trig_q.scale_y;
    prod_d.p10   = trig_q.s * trig_q.scale_x;
    prod_d.p11   = trig_q.c * trig_q.scale_y;
    prod_d.crx   = trig_q.c * trig_q.rx;
    prod_d.sry   = trig_q.s * trig_q.ry;
    prod_d.srx   = trig_q.s * trig_q.rx;
    prod_d.cry   = trig_q.c * trig_q.ry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else if (prod_rdy) begin
      prod_vld_q <= trig_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_rdy) begin
      prod_q <= prod_d;
    end
  end

  // round, sum the translation and saturate into the output register
  logic [191:0] out_d;

  always_comb begin
    logic signed [47:0] rotx, roty, tx, ty;
    rotx = 48'(rnd_q30(prod_q.crx)) - 48'(rnd_q30(prod_q.sry));
    roty = 48'(rnd_q30(prod_q.srx)) + 48'(rnd_q30(prod_q.cry));
    tx   = 48'(prod_q.pos_x) + 48'(prod_q.rx) - rotx;
    ty   = 48'(prod_q.pos_y) + 48'(prod_q.ry) - roty;
    out_d[31:0]    = sat32(48'(rnd_q30(prod_q.p00)));
    out_d[63:32]   = sat32(48'(rnd_q30(prod_q.p01)));
    out_d[95:64]   = sat32(48'(rnd_q30(prod_q.p10)));
    out_d[127:96]  = sat32(48'(rnd_q30(prod_q.p11)));
    out_d[159:128] = sat32(tx);
    out_d[191:160] = sat32(ty);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= prod_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // an empty output register frees the whole chain
  `SAMB_ASSERT_IMP(a_empty_out_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  // an accepted beat lands in the entry stage
  `SAMB_ASSERT_NXT(a_entry_loaded, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0])
  // a finished product moving on reaches the output register
  `SAMB_ASSERT_NXT(a_prod_to_out, clk_i, rst_ni, prod_vld_q && out_rdy, m_axis_tvalid)

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for sprite_affine_matrix_builder_top
// predicts each affine matrix beat in place; depends on samb_pkg and the top level
module testbench;
  import samb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Iterations = 16;
  // pipeline depth of the block, input beat to output beat
  localparam int unsigned Latency = Iterations + 4;
  // cycles without any accepted beat before the run is declared hung
  localparam int unsigned HangLimit = 5000;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam longint AtanStep [24] = '{
    536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [0:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // pos_x, pos_y, angle_turns, scale_x, scale_y from the lowest bit up
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // m00, m01, m10, m11, trans_x, trans_y from the lowest bit up
  logic [191:0] m_axis_tdata;

  sprite_affine_matrix_builder_top #(.SINCOS_ITERATIONS(Iterations)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #2 clk_i = ~clk_i;

  // testbench copy of the pivot registers
  logic signed [15:0] pivot_x_q = 16'sd8192;
  logic signed [15:0] pivot_y_q = 16'sd8192;

  logic [191:0] expected_mats[$];
  int unsigned  err_count = 0;
  int unsigned  beats_in = 0;
  int unsigned  beats_out = 0;

  // receiver behavior: percentage of cycles ready, and a long hold-off counter
  int unsigned  ready_pct = 100;
  int unsigned  hold_off = 0;
  // sender bursts
  int unsigned  burst_left = 0;
  bit           gaps_on = 1'b0;

  function automatic longint round_q30(input longint trig, input longint v);
    return (trig * v + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // full matrix for one input beat under the current pivots
  function automatic logic [191:0] predict_matrix(input logic [143:0] beat);
    longint px, py, sx, sy, pvx, pvy;
    longint x, y, z, dx, dy, c, s, rx, ry, rotx, roty;
    logic [31:0] a, sum, rb;
    logic [1:0] quad;
    px = longint'($signed(beat[31:0]));
    py = longint'($signed(beat[63:32]));
    sx = longint'($signed(beat[111:80]));
    sy = longint'($signed(beat[143:112]));
    pvx = longint'(pivot_x_q);
    pvy = longint'(pivot_y_q);
    // nearest quarter turn, then a signed residual for the cordic
    a = {beat[79:64], 16'h0000};
    sum = a + 32'h2000_0000;
    quad = sum[31:30];
    rb = a - {quad, 30'b0};
    z = longint'($signed(rb));
    x = 652032874;
    y = 0;
    for (int i = 0; i < Iterations && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= AtanStep[i];
      end else begin
        x += dx;
        y -= dy;
        z += AtanStep[i];
      end
    end
    case (quad)
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      2'd3: begin c = y; s = -x; end
      default: begin c = x; s = y; end
    endcase
    rx = (pvx * sx + 8192) >>> 14;
    ry = (pvy * sy + 8192) >>> 14;
    rotx = round_q30(c, rx) - round_q30(s, ry);
    roty = round_q30(s, rx) + round_q30(c, ry);
    return {clamp32(py + ry - roty), clamp32(px + rx - rotx),
            clamp32(round_q30(c, sy)), clamp32(round_q30(s, sx)),
            clamp32(round_q30(-s, sy)), clamp32(round_q30(c, sx))};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at beat %0d: got %h want %h", what, beats_out, got, want);
    err_count++;
  endtask

  // input monitor: sampled mid-cycle, so values are the ones the edge will see
  always @(negedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_mats.push_back(predict_matrix(s_axis_tdata));
      beats_in++;
    end
  end

  // result checker
  always @(negedge clk_i) begin
    logic [191:0] want;
    string names [6];
    names = '{"m00", "m01", "m10", "m11", "trans_x", "trans_y"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_mats.size() == 0) begin
        $display("unexpected result beat %h", m_axis_tdata);
        err_count++;
      end else begin
        want = expected_mats.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (m_axis_tdata[f*32 +: 32] !== want[f*32 +: 32])
            report_mismatch(names[f], m_axis_tdata[f*32 +: 32], want[f*32 +: 32]);
        end
      end
      beats_out++;
    end
  end

  // receiver stall pattern, with an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    static int unsigned quiet = 0;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= HangLimit) begin
        $display("timeout: no beat for %0d cycles", quiet);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // offer one beat and wait until it is taken
  task automatic send_beat(input logic [31:0] px, input logic [31:0] py,
                           input logic [15:0] ang, input logic [31:0] sx,
                           input logic [31:0] sy);
    bit taken;
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sy, sx, ang, py, px};
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // lower valid and wait until every result is back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_pivot(input reg_idx_e idx, input logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PIVOT_X) pivot_x_q = val;
    else pivot_y_q = val;
  endtask

  // mixes full-range words with the interesting corners of Q16.16
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000 + $urandom_range(0, 255) - 128;
      4: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      // near the quarter-turn rounding points
      0: return 16'({2'($urandom_range(0, 3)), 14'h0} + 16'h2000
                    + $urandom_range(0, 2) - 1);
      1: return {2'($urandom_range(0, 3)), 14'h0};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random(input int unsigned n);
    for (int i = 0; i < n; i++)
      send_beat(rand_word(), rand_word(), rand_angle(), rand_word(), rand_word());
  endtask

  // corners of each field, every quadrant and the quarter-turn boundaries
  task automatic test_directed;
    logic [15:0] angs [12];
    angs = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h0001,
             16'h1fff, 16'h2000, 16'h6000, 16'ha000, 16'he000, 16'hdfff};
    gaps_on = 1'b0;
    ready_pct = 100;
    foreach (angs[k]) send_beat(32'h0001_0000, 32'hffff_0000, angs[k], 32'h0040_0000,
                                32'h0020_0000);
    send_beat(32'h7fff_ffff, 32'h7fff_ffff, 16'h0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h8000_0000, 32'h8000_0000);
    send_beat(32'h8000_0000, 32'h7fff_ffff, 16'h4000, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(32'h0, 32'h0, 16'h2000, 32'h0, 32'h0);
    send_beat(32'hffff_ffff, 32'h1, 16'hffff, 32'hffff_ffff, 32'h1);
    drain();
  endtask

  // pivot registers at their extremes, with saturating sizes
  task automatic test_pivot_extremes;
    write_pivot(REG_PIVOT_X, 16'h8000);
    write_pivot(REG_PIVOT_Y, 16'h7fff);
    send_beat(32'h7fff_ffff, 32'h8000_0000, 16'h2000, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(32'h8000_0000, 32'h7fff_ffff, 16'h6000, 32'h7fff_ffff, 32'h8000_0000);
    send_random(6);
    write_pivot(REG_PIVOT_X, 16'h7fff);
    write_pivot(REG_PIVOT_Y, 16'h8000);
    send_random(6);
    write_pivot(REG_PIVOT_X, 16'h0000);
    write_pivot(REG_PIVOT_Y, 16'h0000);
    send_random(6);
    drain();
  endtask

  // random beats under several pivot settings and stall patterns
  task automatic test_random_phases;
    for (int p = 0; p < 6; p++) begin
      write_pivot(REG_PIVOT_X, 16'($urandom_range(0, 65535)));
      write_pivot(REG_PIVOT_Y, 16'($urandom_range(0, 65535)));
      gaps_on = (p % 3) != 0;
      ready_pct = (p == 0) ? 100 : $urandom_range(30, 95);
      send_random(180);
    end
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure;
    write_pivot(REG_PIVOT_X, 16'sd8192);
    write_pivot(REG_PIVOT_Y, 16'sd8192);
    gaps_on = 1'b0;
    ready_pct = 70;
    hold_off = 400;
    send_random(80);
    // sender pauses here until every result is back
    drain();
    send_random(40);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pivot_extremes();
    test_random_phases();
    test_backpressure();
    $display("covered %0d input beats and %0d result beats over corner, pivot,",
             beats_in, beats_out);
    $display("random and back-pressure phases");
    if (err_count == 0 && expected_mats.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches, %0d results missing", err_count, expected_mats.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
